### src/gcf_pkg.sv
`default_nettype none
package gcf_pkg;

  localparam int COUNT_BITS  = 20;
  localparam int RECORD_BITS = 16;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_FIELD_W = RECORD_BITS + 2 * COUNT_BITS;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_USER_W  = 2;

  localparam logic [7:0] CH_HDR = 8'h3E;  // '>'
  localparam logic [7:0] CH_A   = 8'h41;
  localparam logic [7:0] CH_C   = 8'h43;
  localparam logic [7:0] CH_G   = 8'h47;
  localparam logic [7:0] CH_T   = 8'h54;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [RECORD_BITS-1:0] recno_t;

  typedef enum logic [2:0] {
    CLS_HDR,
    CLS_GC,
    CLS_AT,
    CLS_LF,
    CLS_CR,
    CLS_OTHER
  } byte_cls_t;

  typedef struct packed {
    byte_cls_t cls;
    logic      fin;
  } q_item_t;

  typedef struct packed {
    recno_t rec;
    count_t gc;
    count_t total;
    logic   fin;
    logic   err;
  } close_t;

endpackage
`default_nettype wire

### src/gcf_front.sv
`default_nettype none
module gcf_front import gcf_pkg::*; (
  input  wire logic [IN_DATA_W-1:0] text_byte,
  input  wire logic                 final_byte,
  output q_item_t                   item
);

  byte_cls_t cls;

  always_comb begin
    case (text_byte)
      CH_HDR:       cls = CLS_HDR;
      CH_G, CH_C:   cls = CLS_GC;
      CH_A, CH_T:   cls = CLS_AT;
      CH_LF:        cls = CLS_LF;
      CH_CR:        cls = CLS_CR;
      default:      cls = CLS_OTHER;
    endcase
  end

  assign item = '{cls: cls, fin: final_byte};

endmodule
`default_nettype wire

### src/gcf_queue.sv
`default_nettype none
module gcf_queue import gcf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire q_item_t push_item,
  output logic      full,
  input  wire logic pop,
  output q_item_t   pop_item,
  output logic      not_empty
);

  q_item_t    mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign pop_item  = mem_r[rd_ptr_r];
  assign not_empty = (cnt_r != 2'd0);
  assign full      = cnt_r[1];

endmodule
`default_nettype wire

### src/gcf_tally.sv
`default_nettype none
module gcf_tally import gcf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic item_valid,
  input  wire q_item_t item,
  output logic      item_pop,
  input  wire logic close_ready,
  output logic      close_push,
  output close_t    close_item
);

  localparam count_t COUNT_MAX  = '1;
  localparam recno_t RECORD_MAX = '1;

  logic   line_start_r, line_start_nxt;
  logic   in_header_r,  in_header_nxt;
  count_t gc_r,         gc_nxt;
  count_t total_r,      total_nxt;
  recno_t rec_r,        rec_nxt;
  logic   err_r,        err_nxt;
  logic   count_gc, count_at, hdr_close;

  assign item_pop = item_valid && close_ready;

  always_comb begin
    line_start_nxt = line_start_r;
    in_header_nxt  = in_header_r;
    rec_nxt        = rec_r;
    err_nxt        = err_r;
    hdr_close      = 1'b0;
    count_gc       = 1'b0;
    count_at       = 1'b0;
    if (line_start_r) begin
      case (item.cls)
        CLS_HDR: begin
          hdr_close      = 1'b1;
          rec_nxt        = (rec_r != RECORD_MAX) ? rec_r + 1'b1 : rec_r;
          in_header_nxt  = 1'b1;
          line_start_nxt = 1'b0;
        end
        CLS_GC, CLS_AT: begin
          in_header_nxt  = 1'b0;
          line_start_nxt = 1'b0;
          count_gc       = (item.cls == CLS_GC);
          count_at       = (item.cls == CLS_AT);
        end
        CLS_LF, CLS_CR: begin
        end
        default: begin
          err_nxt        = 1'b1;
          in_header_nxt  = 1'b1;
          line_start_nxt = 1'b0;
        end
      endcase
    end else if (item.cls == CLS_LF) begin
      line_start_nxt = 1'b1;
      in_header_nxt  = 1'b0;
    end else if (!in_header_r) begin
      count_gc = (item.cls == CLS_GC);
      count_at = (item.cls == CLS_AT);
    end

    if (hdr_close) begin
      gc_nxt    = '0;
      total_nxt = '0;
    end else begin
      gc_nxt    = (count_gc && gc_r != COUNT_MAX) ? gc_r + 1'b1 : gc_r;
      total_nxt = ((count_gc || count_at) && total_r != COUNT_MAX) ?
                  total_r + 1'b1 : total_r;
    end
  end

  // header + final: a single close carries the live record and marks the stream end
  always_comb begin
    close_push       = item_pop && (hdr_close || item.fin);
    close_item.fin   = item.fin;
    close_item.err   = err_nxt;
    close_item.rec   = rec_r;
    close_item.gc    = hdr_close ? gc_r    : gc_nxt;
    close_item.total = hdr_close ? total_r : total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_start_r <= 1'b1;
      in_header_r  <= 1'b0;
      gc_r         <= '0;
      total_r      <= '0;
      rec_r        <= '0;
      err_r        <= 1'b0;
    end else if (item_pop) begin
      if (item.fin) begin
        line_start_r <= 1'b1;
        in_header_r  <= 1'b0;
        gc_r         <= '0;
        total_r      <= '0;
        rec_r        <= '0;
        err_r        <= 1'b0;
      end else begin
        line_start_r <= line_start_nxt;
        in_header_r  <= in_header_nxt;
        gc_r         <= gc_nxt;
        total_r      <= total_nxt;
        rec_r        <= rec_nxt;
        err_r        <= err_nxt;
      end
    end
  end

endmodule
`default_nettype wire

### src/gcf_judge.sv
`default_nettype none
module gcf_judge import gcf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  close_push,
  input  wire close_t                close_item,
  output logic                       close_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [OUT_FIELD_W-1:0]     out_fields,
  output logic [OUT_USER_W-1:0]      out_flags
);

  close_t cl_r;
  logic   cl_valid_r;
  recno_t win_rec_r,   win_rec_nxt;
  count_t win_gc_r,    win_gc_nxt;
  count_t win_total_r, win_total_nxt;
  logic   win_valid_r, win_valid_nxt;
  logic   out_valid_r;
  logic [OUT_FIELD_W-1:0] out_fields_r;
  logic [OUT_USER_W-1:0]  out_flags_r;

  logic [2*COUNT_BITS-1:0] lhs, rhs;
  logic wins, cl_done;

  assign lhs  = (2*COUNT_BITS)'(cl_r.gc) * (2*COUNT_BITS)'(win_total_r);
  assign rhs  = (2*COUNT_BITS)'(win_gc_r) * (2*COUNT_BITS)'(cl_r.total);
  assign wins = (cl_r.gc != '0) && (cl_r.total != '0) && (!win_valid_r || lhs > rhs);

  assign cl_done     = cl_valid_r && (!cl_r.fin || !out_valid_r || out_ready);
  assign close_ready = !cl_valid_r || cl_done;

  always_comb begin
    win_rec_nxt   = win_rec_r;
    win_gc_nxt    = win_gc_r;
    win_total_nxt = win_total_r;
    win_valid_nxt = win_valid_r;
    if (wins) begin
      win_rec_nxt   = cl_r.rec;
      win_gc_nxt    = cl_r.gc;
      win_total_nxt = cl_r.total;
      win_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl_valid_r  <= 1'b0;
      win_rec_r   <= '0;
      win_gc_r    <= '0;
      win_total_r <= '0;
      win_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (close_push) begin
        cl_valid_r <= 1'b1;
      end else if (cl_done) begin
        cl_valid_r <= 1'b0;
      end

      if (cl_done && cl_r.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cl_done) begin
        if (cl_r.fin) begin
          win_rec_r   <= '0;
          win_gc_r    <= '0;
          win_total_r <= '0;
          win_valid_r <= 1'b0;
        end else begin
          win_rec_r   <= win_rec_nxt;
          win_gc_r    <= win_gc_nxt;
          win_total_r <= win_total_nxt;
          win_valid_r <= win_valid_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (close_push) begin
      cl_r <= close_item;
    end
    if (cl_done && cl_r.fin) begin
      out_fields_r <= {win_total_nxt, win_gc_nxt, win_rec_nxt};
      out_flags_r  <= {cl_r.err, win_valid_nxt};
    end
  end

  assign out_valid  = out_valid_r;
  assign out_fields = out_fields_r;
  assign out_flags  = out_flags_r;

endmodule
`default_nettype wire

### src/fasta_max_gc_content.sv
// channel | ports                     | contents
// --------+---------------------------+------------------------------------------
// in      | in_tvalid/tready/tdata/tlast | tdata[7:0] text byte, tlast final byte
// out     | out_tvalid/tready/tdata/tuser | tdata record, gc, total; tuser found, err
//
// One byte per cycle sustained while the result is not stalled: classifier feeds a
// 2-entry queue, the line parser takes one entry per cycle, and record closes
// are registered into a compare stage (two 20x20 multiplies and a compare).
// out_tvalid rises once the final byte has passed the queue, the close register and the output register.
// rst_n is synchronous; after it, and after each final byte, a new stream starts.
// A stalled result stalls the compare stage only on the next final byte.
`default_nettype none
module fasta_max_gc_content import gcf_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_DATA_W-1:0]   in_tdata,   // [7:0] text_byte
  input  wire logic                   in_tlast,   // final_byte
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_DATA_W-1:0]       out_tdata,  // best_record, best_gc_bases, best_total_bases
  output logic [OUT_USER_W-1:0]       out_tuser   // found, format_error
);

  q_item_t fr_item, q_item;
  logic    q_full, q_not_empty, q_pop;
  logic    cl_push, cl_ready;
  close_t  cl_item;
  logic [OUT_FIELD_W-1:0] fields;

  gcf_front u_front (
    .text_byte  (in_tdata),
    .final_byte (in_tlast),
    .item       (fr_item)
  );

  gcf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid && !q_full),
    .push_item (fr_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .not_empty (q_not_empty)
  );

  gcf_tally u_tally (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (q_not_empty),
    .item        (q_item),
    .item_pop    (q_pop),
    .close_ready (cl_ready),
    .close_push  (cl_push),
    .close_item  (cl_item)
  );

  gcf_judge u_judge (
    .clk         (clk),
    .rst_n       (rst_n),
    .close_push  (cl_push),
    .close_item  (cl_item),
    .close_ready (cl_ready),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_fields  (fields),
    .out_flags   (out_tuser)
  );

  assign in_tready = !q_full;
  assign out_tdata = OUT_DATA_W'(fields);

endmodule
`default_nettype wire
